// ----- hdl/cpe_pkg.sv -----
// cpe_pkg: shared types, constants and register indexes of the coefficient parity embedder
// used by every module under hdl; no dependencies of its own

package cpe_pkg;

    // change counter width and its saturation value
    localparam int unsigned COUNT_BITS = 32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration port geometry
    localparam int unsigned CFG_INDEX_BITS = 1;
    localparam int unsigned CFG_DATA_BITS  = 64;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEED  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT = 1'd1;

    // mixer constants
    localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MUL_ONE    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MUL_TWO    = 64'h94d049bb133111eb;
    localparam logic [63:0] DIR_DOMAIN = 64'h5844535443444952;
    localparam int unsigned SHIFT_ONE  = 30;
    localparam int unsigned SHIFT_TWO  = 27;
    localparam int unsigned SHIFT_FIN  = 31;

    // saturation edges of the coefficient range
    localparam logic signed [15:0] UPPER_EDGE = 16'sd1023;
    localparam logic signed [15:0] LOWER_EDGE = -16'sd1023;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // what the back part does to the coefficient
    typedef enum logic [1:0] {
        ACT_KEEP,
        ACT_UP,
        ACT_DOWN,
        ACT_HASH
    } act_t;

    // input request
    typedef struct packed {
        logic signed [15:0] coefficient;
        logic [31:0]        offset;
        logic [31:0]        item_position;
        logic               desired_bit;
        logic               last;
    } item_t;

    // result request
    typedef struct packed {
        logic signed [15:0] new_coefficient;
        logic               changed;
        logic               out_of_range;
        logic [31:0]        changes_so_far;
        logic               last_out;
    } result_t;

    // classified item travelling from front to back
    typedef struct packed {
        act_t               act;
        logic signed [15:0] coefficient;
        logic [63:0]        mix;
        logic               changed;
        logic               out_of_range;
        logic [31:0]        changes_so_far;
        logic               last;
    } work_t;

endpackage

// ----- hdl/cpe_front.sv -----
// cpe_front: configuration registers, range check, step classification and change counter
// depends on cpe_pkg

module cpe_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [cpe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cpe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  cpe_pkg::item_t                      item,
    input  logic                                accept,
    output cpe_pkg::work_t                      work
);

    logic [63:0]                     seed_reg;
    logic [31:0]                     coef_count_reg;
    logic [cpe_pkg::COUNT_BITS-1:0]  count_reg;
    logic [cpe_pkg::COUNT_BITS-1:0]  count_next;
    logic [cpe_pkg::COUNT_BITS-1:0]  count_after;
    logic                            oor;
    logic                            needs_change;
    cpe_pkg::act_t                   act;
    logic [63:0]                     mix_in;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= '0;
            coef_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cpe_pkg::REG_SEED:  seed_reg       <= cfg_data[63:0];
                cpe_pkg::REG_COUNT: coef_count_reg <= cfg_data[31:0];
                default:            ;
            endcase
        end
    end

    // range check and parity test
    assign oor          = (item.offset >= coef_count_reg);
    assign needs_change = !oor && (item.coefficient[0] != item.desired_bit);

    // step classification, edges first
    always_comb
    begin
        if (!needs_change)
            act = cpe_pkg::ACT_KEEP;
        else if (item.coefficient <= cpe_pkg::LOWER_EDGE)
            act = cpe_pkg::ACT_UP;
        else if (item.coefficient >= cpe_pkg::UPPER_EDGE)
            act = cpe_pkg::ACT_DOWN;
        else
            act = cpe_pkg::ACT_HASH;
    end

    // mixer input; the golden increment is added when the work item is formed
    assign mix_in = seed_reg ^ cpe_pkg::DIR_DOMAIN ^ {32'd0, item.offset}
                    ^ {item.item_position, 32'd0};

    // saturating change counter, cleared after the last item
    always_comb
    begin
        count_after = count_reg;
        if (needs_change && (count_reg != cpe_pkg::COUNT_MAX))
            count_after = count_reg + {{(cpe_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
        count_next = count_reg;
        if (accept)
            count_next = item.last ? '0 : count_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // classified item to the queue
    always_comb
    begin
        work.act            = act;
        work.coefficient    = item.coefficient;
        work.mix            = mix_in + cpe_pkg::GOLDEN_INC;
        work.changed        = needs_change;
        work.out_of_range   = oor;
        work.changes_so_far = 32'(count_after);
        work.last           = item.last;
    end

endmodule

// ----- hdl/cpe_queue.sv -----
// cpe_queue: short first-in first-out queue of classified items between front and back
// depends on cpe_pkg

module cpe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cpe_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output cpe_pkg::work_t head
);

    cpe_pkg::work_t                      entry_reg [cpe_pkg::QUEUE_DEPTH];
    logic [cpe_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg;
    logic [cpe_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_next;
    logic [cpe_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_reg;
    logic [cpe_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_next;
    logic [cpe_pkg::QUEUE_CNT_BITS-1:0]  fill_reg;
    logic [cpe_pkg::QUEUE_CNT_BITS-1:0]  fill_next;
    logic                                do_push;
    logic                                do_pop;

    assign full      = (fill_reg == cpe_pkg::QUEUE_CNT_BITS'(cpe_pkg::QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (!do_push && do_pop)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hdl/cpe_back.sv -----
// cpe_back: three-stage mixer pipeline that picks the step direction and forms the result
// depends on cpe_pkg

module cpe_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  cpe_pkg::work_t  head,
    output logic            pop,
    output logic            result_valid,
    input  logic            result_ready,
    output cpe_pkg::result_t result
);

    logic              advance;

    // stage one: partial products of the first multiply
    logic              s1_valid_reg;
    cpe_pkg::work_t    s1_work_reg;
    logic [63:0]       s1_p0_reg;
    logic [31:0]       s1_p1_reg;
    logic [31:0]       s1_p2_reg;
    logic [63:0]       y1;
    logic [63:0]       p0_next;
    logic [31:0]       p1_next;
    logic [31:0]       p2_next;

    // stage two: folded low word of the first product
    logic              s2_valid_reg;
    cpe_pkg::work_t    s2_work_reg;
    logic [31:0]       s2_y2_reg;
    logic [63:0]       x1;
    logic [31:0]       y2_next;

    // stage three: output register
    logic              out_valid_reg;
    cpe_pkg::result_t  out_reg;
    cpe_pkg::result_t  out_next;
    logic [31:0]       x2;
    logic              dir_up;

    // whole pipeline moves while the output register can take a result
    assign advance      = !out_valid_reg || result_ready;
    assign pop          = advance && head_valid;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // first xor-shift and split multiply
    always_comb
    begin
        y1      = head.mix ^ (head.mix >> cpe_pkg::SHIFT_ONE);
        p0_next = y1[31:0] * cpe_pkg::MUL_ONE[31:0];
        p1_next = y1[63:32] * cpe_pkg::MUL_ONE[31:0];
        p2_next = y1[31:0] * cpe_pkg::MUL_ONE[63:32];
    end

    // recombine, second xor-shift; only the low word matters from here on
    always_comb
    begin
        x1      = s1_p0_reg + {s1_p1_reg + s1_p2_reg, 32'd0};
        y2_next = x1[31:0] ^ x1[58:27];
    end

    // second multiply, final fold down to bit zero
    always_comb
    begin
        x2     = s2_y2_reg * cpe_pkg::MUL_TWO[31:0];
        dir_up = x2[0] ^ x2[cpe_pkg::SHIFT_FIN];
    end

    // apply the step
    always_comb
    begin
        out_next.changed        = s2_work_reg.changed;
        out_next.out_of_range   = s2_work_reg.out_of_range;
        out_next.changes_so_far = s2_work_reg.changes_so_far;
        out_next.last_out       = s2_work_reg.last;
        case (s2_work_reg.act)
            cpe_pkg::ACT_KEEP: out_next.new_coefficient = s2_work_reg.coefficient;
            cpe_pkg::ACT_UP:   out_next.new_coefficient = s2_work_reg.coefficient + 16'sd1;
            cpe_pkg::ACT_DOWN: out_next.new_coefficient = s2_work_reg.coefficient - 16'sd1;
            cpe_pkg::ACT_HASH:
            begin
                if (dir_up)
                    out_next.new_coefficient = s2_work_reg.coefficient + 16'sd1;
                else
                    out_next.new_coefficient = s2_work_reg.coefficient - 16'sd1;
            end
            default:           out_next.new_coefficient = s2_work_reg.coefficient;
        endcase
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= head_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_work_reg <= head;
            s1_p0_reg   <= p0_next;
            s1_p1_reg   <= p1_next;
            s1_p2_reg   <= p2_next;
            s2_work_reg <= s1_work_reg;
            s2_y2_reg   <= y2_next;
            out_reg     <= out_next;
        end
    end

endmodule

// ----- hdl/coefficient_parity_embedder_core.sv -----
// coefficient_parity_embedder_core: top level joining front, queue and back
// an accepted item passes the queue, mixer stages one and two and the output register
// throughput: one item per cycle unless result_ready stalls the mixer and output register
// the four-entry queue lets the front keep accepting while the back is stalled
// reset: clears seed, coefficient count, change counter, queue and all stage valid bits
// depends on cpe_pkg, cpe_front, cpe_queue, cpe_back

module coefficient_parity_embedder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [cpe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cpe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  cpe_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output cpe_pkg::result_t                    result
);

    cpe_pkg::work_t work;
    cpe_pkg::work_t head;
    logic           accept;
    logic           q_full;
    logic           q_not_empty;
    logic           pop;

    assign item_ready = !q_full;
    assign accept     = item_valid && item_ready;

    // classify and count
    cpe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .accept    (accept),
        .work      (work)
    );

    // decoupling queue
    cpe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (work),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    // mixer and result
    cpe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_not_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
